[src/mal_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC learning table package
// Shared constants, the job record passed from front to back, and the CRC step.
// ----------------------------------------------------------------------------
package mal_pkg;

  localparam int NUM_BUCKETS_DEF = 256;
  localparam int CAPACITY_DEF    = 1024;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] STAT_HIT  = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic [31:0] CRC_POLY        = 32'h04C1_1DB7;
  localparam logic [10:0] MAX_ENTRIES_RST = 11'd1024;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] addr;
    logic [31:0] val;
    logic [31:0] crc;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[src/mac_address_learning_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC address learning table
// Hashed exact-match table of 48-bit addresses with chained buckets.
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_ready with opcode, mac_address and entry_value.
// One result per item leaves on out_valid/out_ready with status, found_value
// and entry_count, in item order. The limit register is written through
// cfg_valid/cfg_ready/cfg_data, which is always ready.
// The front end computes the CRC bucket hash one address byte per cycle. The
// back end reads the bucket head and then visits the chain links one by one
// through the registered read of the chain memories; a delete adds a second
// write step, and an insert of a new address first takes a free slot.
// A two-entry queue lets hashing of the next item overlap the chain walk.
// Reset empties all buckets at once and sets the limit to 1024; no clearing
// pass is needed. While the receiver stalls, the pending result holds and the
// back end takes no new job, while the front keeps hashing into the queue.
// ----------------------------------------------------------------------------
module mac_address_learning_table #(
  parameter int NUM_BUCKETS = mal_pkg::NUM_BUCKETS_DEF,
  parameter int CAPACITY    = mal_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [47:0] mac_address,
  input  logic [31:0] entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] found_value,
  output logic [10:0] entry_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  mal_pkg::job_t f_data;
  mal_pkg::job_t b_data;
  logic          f_valid;
  logic          f_ready;
  logic          b_valid;
  logic          b_ready;
  logic [10:0]   max_entries;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= mal_pkg::MAX_ENTRIES_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_entries <= cfg_data;
    end
  end

  mal_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .mac_address (mac_address),
    .entry_value (entry_value),
    .q_valid     (f_valid),
    .q_ready     (f_ready),
    .q_data      (f_data)
  );

  mal_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .s_valid (f_valid),
    .s_ready (f_ready),
    .s_data  (f_data),
    .m_valid (b_valid),
    .m_ready (b_ready),
    .m_data  (b_data)
  );

  mal_back #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .CAPACITY    (CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (b_valid),
    .job_ready   (b_ready),
    .job         (b_data),
    .max_entries (max_entries),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_value (found_value),
    .entry_count (entry_count)
  );

endmodule

[src/mal_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC learning table front end
// Accepts an item and hashes its address one byte per cycle into a job.
// ----------------------------------------------------------------------------
module mal_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    opcode,
  input  logic [47:0]   mac_address,
  input  logic [31:0]   entry_value,
  output logic          q_valid,
  input  logic          q_ready,
  output mal_pkg::job_t q_data
);

  logic          busy;
  logic          hashed;
  logic [2:0]    cnt;
  mal_pkg::job_t job;
  logic [7:0]    byte_sel;

  always_comb begin
    case (cnt)
      3'd0:    byte_sel = job.addr[47:40];
      3'd1:    byte_sel = job.addr[39:32];
      3'd2:    byte_sel = job.addr[31:24];
      3'd3:    byte_sel = job.addr[23:16];
      3'd4:    byte_sel = job.addr[15:8];
      default: byte_sel = job.addr[7:0];
    endcase
  end

  assign in_ready = !busy;
  assign q_valid  = busy && hashed;
  assign q_data   = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      hashed <= 1'b0;
      cnt    <= 3'd0;
    end else if (!busy) begin
      if (in_valid) begin
        busy   <= 1'b1;
        hashed <= 1'b0;
        cnt    <= 3'd0;
      end
    end else if (!hashed) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd5) begin
        hashed <= 1'b1;
      end
    end else if (q_ready) begin
      busy   <= 1'b0;
      hashed <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && in_valid) begin
      job.op   <= opcode;
      job.addr <= mac_address;
      job.val  <= entry_value;
      job.crc  <= 32'h0;
    end else if (busy && !hashed) begin
      job.crc <= mal_pkg::crc_byte(job.crc, byte_sel);
    end
  end

endmodule

[src/mal_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC learning table job queue
// Two-entry queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module mal_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  mal_pkg::job_t s_data,
  output logic          m_valid,
  input  logic          m_ready,
  output mal_pkg::job_t m_data
);

  mal_pkg::job_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;
  logic          pop;

  assign s_ready = (fill != 2'd2);
  assign m_valid = (fill != 2'd0);
  assign m_data  = slots[rd_ptr];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= s_data;
    end
  end

endmodule

[src/mal_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC learning table back end
// Walks the bucket chain in memory and carries out lookup, insert and delete.
// ----------------------------------------------------------------------------
module mal_back #(
  parameter int NUM_BUCKETS = mal_pkg::NUM_BUCKETS_DEF,
  parameter int CAPACITY    = mal_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  mal_pkg::job_t job,
  input  logic [10:0]   max_entries,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output logic [31:0]   found_value,
  output logic [10:0]   entry_count
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HEAD  = 4'd1;
  localparam logic [3:0] S_HEADW = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_DEL2  = 4'd5;
  localparam logic [3:0] S_ARD   = 4'd6;
  localparam logic [3:0] S_ALLOC = 4'd7;
  localparam logic [3:0] S_INS   = 4'd8;

  logic [PW-1:0] head_mem [NUM_BUCKETS];
  logic          bvalid   [NUM_BUCKETS];
  logic [47:0]   addr_mem [CAPACITY];
  logic [31:0]   val_mem  [CAPACITY];
  logic [PW-1:0] next_mem [CAPACITY];

  logic [3:0]    state;
  mal_pkg::job_t cur_job;
  logic [PW-1:0] cur;
  logic [PW-1:0] prev;
  logic [PW-1:0] steps;
  logic [PW-1:0] head_val;
  logic [PW-1:0] count;
  logic [PW-1:0] fresh;
  logic [PW-1:0] rec_head;
  logic [PW-1:0] new_slot;

  logic [PW-1:0] head_rd;
  logic          hv_rd;
  logic [47:0]   a_rd;
  logic [31:0]   v_rd;
  logic [PW-1:0] n_rd;

  logic [BW-1:0] bkt;
  logic [IW-1:0] rd_idx;
  logic          full;
  logic          hit;

  logic          hd_we;
  logic [PW-1:0] hd_wd;
  logic          nx_we;
  logic [IW-1:0] nx_wa;
  logic [PW-1:0] nx_wd;

  assign bkt       = cur_job.crc[BW-1:0];
  assign rd_idx    = (state == S_ARD) ? rec_head[IW-1:0] : cur[IW-1:0];
  assign full      = (32'(count) >= 32'(max_entries)) || (32'(count) >= CAPACITY);
  assign hit       = (a_rd == cur_job.addr);
  assign job_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    hd_we = 1'b0;
    hd_wd = new_slot;
    nx_we = 1'b0;
    nx_wa = new_slot[IW-1:0];
    nx_wd = head_val;
    case (state)
      S_CMP: begin
        if (hit && cur_job.op == mal_pkg::OP_DELETE) begin
          if (prev == NIL) begin
            hd_we = 1'b1;
            hd_wd = n_rd;
          end else begin
            nx_we = 1'b1;
            nx_wa = prev[IW-1:0];
            nx_wd = n_rd;
          end
        end
      end
      S_DEL2: begin
        nx_we = 1'b1;
        nx_wa = cur[IW-1:0];
        nx_wd = rec_head;
      end
      S_INS: begin
        hd_we = 1'b1;
        nx_we = 1'b1;
      end
      default: begin
        hd_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_mem[bkt] <= hd_wd;
    end
    head_rd <= head_mem[bkt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        bvalid[i] <= 1'b0;
      end
      hv_rd <= 1'b0;
    end else begin
      if (hd_we) begin
        bvalid[bkt] <= 1'b1;
      end
      hv_rd <= bvalid[bkt];
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    n_rd <= next_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_INS) begin
      addr_mem[new_slot[IW-1:0]] <= cur_job.addr;
    end
    a_rd <= addr_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_INS) begin
      val_mem[new_slot[IW-1:0]] <= cur_job.val;
    end else if (state == S_CMP && hit && cur_job.op == mal_pkg::OP_INSERT) begin
      val_mem[cur[IW-1:0]] <= cur_job.val;
    end
    v_rd <= val_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      fresh     <= '0;
      rec_head  <= NIL;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            cur_job <= job;
            state   <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (cur_job.op == mal_pkg::OP_LOOKUP || cur_job.op == mal_pkg::OP_INSERT ||
              cur_job.op == mal_pkg::OP_DELETE) begin
            state <= S_HEADW;
          end else begin
            status      <= mal_pkg::STAT_MISS;
            found_value <= 32'h0;
            entry_count <= 11'(count);
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_HEADW: begin
          head_val <= hv_rd ? head_rd : NIL;
          cur      <= hv_rd ? head_rd : NIL;
          prev     <= NIL;
          steps    <= '0;
          state    <= S_WALK;
        end
        S_WALK: begin
          if (cur == NIL || steps == NIL) begin
            if (cur_job.op == mal_pkg::OP_INSERT) begin
              if (full) begin
                status      <= mal_pkg::STAT_FULL;
                found_value <= 32'h0;
                entry_count <= 11'(count);
                out_valid   <= 1'b1;
                state       <= S_IDLE;
              end else if (fresh != NIL) begin
                new_slot <= fresh;
                fresh    <= fresh + PW'(1);
                state    <= S_INS;
              end else begin
                state <= S_ARD;
              end
            end else begin
              status      <= mal_pkg::STAT_MISS;
              found_value <= 32'h0;
              entry_count <= 11'(count);
              out_valid   <= 1'b1;
              state       <= S_IDLE;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            if (cur_job.op == mal_pkg::OP_DELETE) begin
              state <= S_DEL2;
            end else begin
              status      <= mal_pkg::STAT_HIT;
              found_value <= (cur_job.op == mal_pkg::OP_LOOKUP) ? v_rd : 32'h0;
              entry_count <= 11'(count);
              out_valid   <= 1'b1;
              state       <= S_IDLE;
            end
          end else begin
            prev  <= cur;
            cur   <= n_rd;
            steps <= steps + PW'(1);
            state <= S_WALK;
          end
        end
        S_DEL2: begin
          rec_head    <= cur;
          count       <= (count != '0) ? count - PW'(1) : count;
          status      <= mal_pkg::STAT_HIT;
          found_value <= 32'h0;
          entry_count <= 11'((count != '0) ? count - PW'(1) : count);
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        S_ARD: begin
          state <= S_ALLOC;
        end
        S_ALLOC: begin
          new_slot <= rec_head;
          rec_head <= n_rd;
          state    <= S_INS;
        end
        S_INS: begin
          count       <= count + PW'(1);
          status      <= mal_pkg::STAT_HIT;
          found_value <= 32'h0;
          entry_count <= 11'(count + PW'(1));
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) 32'(count) <= CAPACITY)
    else $error("Entry count exceeds capacity.");
  assert property (@(posedge clk) disable iff (rst) 32'(fresh) <= CAPACITY)
    else $error("Fresh slot pointer beyond the pool.");
  assert property (@(posedge clk) disable iff (rst) state != S_IDLE |-> !out_valid)
    else $error("Result pending while an item is in progress.");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> status != 2'd3)
    else $error("Result carries an unused status code.");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC address learning table testbench
// Drives lookups, inserts and deletes through the valid/ready channels. A
// scoreboard keeps its own hashed, chained copy of the table and checks each
// result in order. The limit register is swept through zero, a small value and
// full capacity. Both sides idle at random, and the receiver holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int BUCKETS = 256;
  localparam int SLOTS = 1024;
  localparam logic [10:0] NO_SLOT = 11'd1024;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] found;
    logic [10:0] count;
  } table_result_t;

  class mac_table_scoreboard;
    logic [10:0] heads[BUCKETS];
    logic [47:0] keys[SLOTS];
    logic [31:0] vals[SLOTS];
    logic [10:0] links[SLOTS];
    logic [10:0] free_slot;
    logic [10:0] count;
    logic [10:0] limit;
    table_result_t expected_q[$];
    int errors;

    function new();
      for (int i = 0; i < BUCKETS; i++) heads[i] = NO_SLOT;
      for (int i = 0; i < SLOTS; i++) begin
        keys[i] = '0;
        vals[i] = '0;
        links[i] = 11'(i + 1);
      end
      free_slot = 0;
      count = 0;
      limit = mal_pkg::MAX_ENTRIES_RST;
      errors = 0;
    endfunction

    function logic [7:0] bucket_of(logic [47:0] addr);
      logic [31:0] crc;
      logic fb;
      crc = '0;
      for (int i = 47; i >= 0; i--) begin
        fb = crc[31] ^ addr[i];
        crc = crc << 1;
        if (fb) crc = crc ^ mal_pkg::CRC_POLY;
      end
      return crc[7:0];
    endfunction

    function logic [10:0] find(logic [7:0] bkt, logic [47:0] addr, output logic [10:0] prev);
      logic [10:0] cur;
      int steps;
      cur = heads[bkt];
      prev = NO_SLOT;
      steps = 0;
      while (cur < NO_SLOT && steps < SLOTS) begin
        if (keys[cur] == addr) return cur;
        prev = cur;
        cur = links[cur];
        steps++;
      end
      prev = NO_SLOT;
      return NO_SLOT;
    endfunction

    function void note_item(logic [1:0] op, logic [47:0] addr, logic [31:0] val);
      table_result_t r;
      logic [7:0] bkt;
      logic [10:0] slot;
      logic [10:0] prev;
      r.status = mal_pkg::STAT_MISS;
      r.found = '0;
      bkt = bucket_of(addr);
      slot = find(bkt, addr, prev);
      case (op)
        mal_pkg::OP_LOOKUP: begin
          if (slot < NO_SLOT) begin
            r.status = mal_pkg::STAT_HIT;
            r.found = vals[slot];
          end
        end
        mal_pkg::OP_INSERT: begin
          if (slot < NO_SLOT) begin
            vals[slot] = val;
            r.status = mal_pkg::STAT_HIT;
          end else if (count >= limit || free_slot >= NO_SLOT) begin
            r.status = mal_pkg::STAT_FULL;
          end else begin
            slot = free_slot;
            free_slot = links[slot];
            keys[slot] = addr;
            vals[slot] = val;
            links[slot] = heads[bkt];
            heads[bkt] = slot;
            count++;
            r.status = mal_pkg::STAT_HIT;
          end
        end
        mal_pkg::OP_DELETE: begin
          if (slot < NO_SLOT) begin
            if (prev < NO_SLOT) links[prev] = links[slot];
            else heads[bkt] = links[slot];
            links[slot] = free_slot;
            free_slot = slot;
            if (count > 0) count--;
            r.status = mal_pkg::STAT_HIT;
          end
        end
        default: ;
      endcase
      r.count = count;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] fv, logic [10:0] cnt);
      table_result_t r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: status %0d value %h count %0d",
                                   st, fv, cnt);
        return;
      end
      r = expected_q.pop_front();
      if (st !== r.status || fv !== r.found || cnt !== r.count) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected status %0d value %h count %0d, got %0d %h %0d",
                   r.status, r.found, r.count, st, fv, cnt);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic [47:0] mac_address = '0;
  logic [31:0] entry_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [31:0] found_value;
  logic [10:0] entry_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [10:0] cfg_data = '0;

  mac_table_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int cycles = 0;
  logic [47:0] pool[200];

  mac_address_learning_table u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .mac_address(mac_address), .entry_value(entry_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found_value(found_value), .entry_count(entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(status, found_value, entry_count);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 250;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [47:0] addr, logic [31:0] val);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    mac_address <= addr;
    entry_value <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, addr, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [10:0] lim);
    drain();
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.limit = lim;
  endtask

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic random_items(int n, int pool_size);
    int pick;
    logic [1:0] op;
    logic [47:0] addr;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      addr = pool[$urandom_range(0, pool_size - 1)];
      if (pick < 45) op = mal_pkg::OP_INSERT;
      else if (pick < 75) op = mal_pkg::OP_LOOKUP;
      else if (pick < 92) op = mal_pkg::OP_DELETE;
      else begin
        op = 2'($urandom);
        addr = rand_mac();
      end
      send_item(op, addr, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 200; i++) pool[i] = rand_mac();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_limit(11'd1024);

    send_item(mal_pkg::OP_LOOKUP, 48'h0, 32'h0);
    send_item(mal_pkg::OP_INSERT, 48'h0, 32'h0);
    send_item(mal_pkg::OP_INSERT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(mal_pkg::OP_LOOKUP, 48'h0, 32'h1234_5678);
    send_item(mal_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 32'h0);
    send_item(mal_pkg::OP_INSERT, 48'hFFFF_FFFF_FFFF, 32'hA5A5_5A5A);
    send_item(mal_pkg::OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 32'h0);
    send_item(OP_UNUSED, 48'h0, 32'hFFFF_FFFF);
    send_item(mal_pkg::OP_DELETE, 48'h0, 32'hFFFF_FFFF);
    send_item(mal_pkg::OP_DELETE, 48'h0, 32'h0);
    send_item(mal_pkg::OP_LOOKUP, 48'h0, 32'h0);
    send_item(mal_pkg::OP_INSERT, 48'h5555_5555_5555, 32'h5555_5555);
    send_item(mal_pkg::OP_INSERT, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_item(mal_pkg::OP_LOOKUP, 48'hAAAA_AAAA_AAAA, 32'h0);
    send_item(mal_pkg::OP_DELETE, 48'hFFFF_FFFF_FFFF, 32'h0);

    write_limit(11'd0);
    send_item(mal_pkg::OP_INSERT, 48'h0123_4567_89AB, 32'h1);
    send_item(mal_pkg::OP_INSERT, 48'h5555_5555_5555, 32'h7);
    send_item(mal_pkg::OP_LOOKUP, 48'h5555_5555_5555, 32'h0);
    send_item(mal_pkg::OP_DELETE, 48'h5555_5555_5555, 32'h0);
    send_item(mal_pkg::OP_INSERT, 48'h5555_5555_5555, 32'h7);

    write_limit(11'd4);
    random_items(120, 12);

    write_limit(11'd1024);
    random_items(300, 200);
    hold_req = 1'b1;
    random_items(200, 200);
    drain();
    random_items(300, 200);
    idle_on = 1'b0;
    random_items(200, 200);

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
